[rtl/si2d_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// si2d_pkg
// Shared constants, result codes and pipeline control type for the 2-D
// segment intersection block.
// ---------------------------------------------------------------------------
package si2d_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// result codes
	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_HIT      = 2'd1;
	localparam logic [1:0] ST_COLINEAR = 2'd2;

	// control carried alongside each pipeline stage
	typedef struct packed {
		logic       valid;
		logic [1:0] status;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/si2d_in_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// si2d_in_if
// Input channel: two segments per transfer, valid/ready handshake.
// ---------------------------------------------------------------------------
interface si2d_in_if #(
	parameter int CW = si2d_pkg::COORD_WIDTH_DEF
);
	logic          valid;
	logic          ready;
	logic [CW-1:0] p_start_x;
	logic [CW-1:0] p_start_z;
	logic [CW-1:0] p_end_x;
	logic [CW-1:0] p_end_z;
	logic [CW-1:0] q_start_x;
	logic [CW-1:0] q_start_z;
	logic [CW-1:0] q_end_x;
	logic [CW-1:0] q_end_z;

	modport source (
		output valid, p_start_x, p_start_z, p_end_x, p_end_z,
		       q_start_x, q_start_z, q_end_x, q_end_z,
		input  ready
	);
	modport sink (
		input  valid, p_start_x, p_start_z, p_end_x, p_end_z,
		       q_start_x, q_start_z, q_end_x, q_end_z,
		output ready
	);
endinterface
`default_nettype wire

[rtl/si2d_out_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// si2d_out_if
// Result channel: status, intersection point and parameters per transfer.
// ---------------------------------------------------------------------------
interface si2d_out_if #(
	parameter int CW = si2d_pkg::COORD_WIDTH_DEF,
	parameter int FB = si2d_pkg::FRAC_BITS_DEF
);
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic [CW-1:0] cross_x;
	logic [CW-1:0] cross_z;
	logic [FB:0]   t_frac;
	logic [FB:0]   u_frac;

	modport source (
		output valid, status, cross_x, cross_z, t_frac, u_frac,
		input  ready
	);
	modport sink (
		input  valid, status, cross_x, cross_z, t_frac, u_frac,
		output ready
	);
endinterface
`default_nettype wire

[rtl/si2d_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// si2d_front
// Five-stage front end: differences, products, determinant and cross terms,
// magnitudes, then range check and classification.
// ---------------------------------------------------------------------------
module si2d_front #(
	parameter int CW = si2d_pkg::COORD_WIDTH_DEF,
	localparam int D  = CW + 1,
	localparam int PW = 2 * D,
	localparam int MW = PW - 1,
	localparam int SW = 2 * CW + 2 * D
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [CW-1:0]  p0x,
	input  wire logic [CW-1:0]  p0z,
	input  wire logic [CW-1:0]  p1x,
	input  wire logic [CW-1:0]  p1z,
	input  wire logic [CW-1:0]  q0x,
	input  wire logic [CW-1:0]  q0z,
	input  wire logic [CW-1:0]  q1x,
	input  wire logic [CW-1:0]  q1z,
	output si2d_pkg::ctl_t      ctl,
	output logic [MW-1:0]       den,
	output logic [MW-1:0]       rem_t,
	output logic [MW-1:0]       rem_u,
	output logic [SW-1:0]       side
);

	logic                 v_s1, v_s2, v_s3, v_s4;
	si2d_pkg::ctl_t       ctl_s5;
	logic signed [D-1:0]  a_s1, b_s1, c_s1, d_s1, e_s1, f_s1;
	logic [CW-1:0]        p0x_s1, p0z_s1, p0x_s2, p0z_s2, p0x_s3, p0z_s3;
	logic [CW-1:0]        p0x_s4, p0z_s4;
	logic signed [D-1:0]  a_s2, d_s2, a_s3, d_s3, a_s4, d_s4;
	logic signed [PW-1:0] ae_s2, bd_s2, ce_s2, bf_s2, af_s2, cd_s2;
	logic signed [PW-1:0] det_s3, cot_s3, cou_s3;
	logic [MW-1:0]        mdet_s4, mcot_s4, mcou_s4;
	logic                 zdet_s4, zcot_s4, zcou_s4;
	logic                 ndet_s4, ncot_s4, ncou_s4;
	logic [MW-1:0]        mdet_s5, mcot_s5, mcou_s5;
	logic [SW-1:0]        side_s5;
	logic signed [PW-1:0] ndet, ncot, ncou;
	logic                 t_ok, u_ok;
	logic [1:0]           status_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			ctl_s5 <= '0;
		end else if (en) begin
			v_s1          <= in_valid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			v_s4          <= v_s3;
			ctl_s5.valid  <= v_s4;
			ctl_s5.status <= status_c;
		end
	end

	// stage 1: coordinate differences, one bit wider
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= $signed({p1x[CW-1], p1x}) - $signed({p0x[CW-1], p0x});
			b_s1   <= $signed({q0x[CW-1], q0x}) - $signed({q1x[CW-1], q1x});
			c_s1   <= $signed({q0x[CW-1], q0x}) - $signed({p0x[CW-1], p0x});
			d_s1   <= $signed({p1z[CW-1], p1z}) - $signed({p0z[CW-1], p0z});
			e_s1   <= $signed({q0z[CW-1], q0z}) - $signed({q1z[CW-1], q1z});
			f_s1   <= $signed({q0z[CW-1], q0z}) - $signed({p0z[CW-1], p0z});
			p0x_s1 <= p0x;
			p0z_s1 <= p0z;
		end
	end

	// stage 2: six signed products
	always_ff @(posedge clk) begin
		if (en) begin
			ae_s2  <= a_s1 * e_s1;
			bd_s2  <= b_s1 * d_s1;
			ce_s2  <= c_s1 * e_s1;
			bf_s2  <= b_s1 * f_s1;
			af_s2  <= a_s1 * f_s1;
			cd_s2  <= c_s1 * d_s1;
			a_s2   <= a_s1;
			d_s2   <= d_s1;
			p0x_s2 <= p0x_s1;
			p0z_s2 <= p0z_s1;
		end
	end

	// stage 3: determinant and the two cross terms
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= ae_s2 - bd_s2;
			cot_s3 <= ce_s2 - bf_s2;
			cou_s3 <= af_s2 - cd_s2;
			a_s3   <= a_s2;
			d_s3   <= d_s2;
			p0x_s3 <= p0x_s2;
			p0z_s3 <= p0z_s2;
		end
	end

	// stage 4: signs, zero flags and magnitudes
	assign ndet = -det_s3;
	assign ncot = -cot_s3;
	assign ncou = -cou_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			zdet_s4 <= (det_s3 == '0);
			zcot_s4 <= (cot_s3 == '0);
			zcou_s4 <= (cou_s3 == '0);
			ndet_s4 <= det_s3[PW-1];
			ncot_s4 <= cot_s3[PW-1];
			ncou_s4 <= cou_s3[PW-1];
			mdet_s4 <= det_s3[PW-1] ? ndet[MW-1:0] : det_s3[MW-1:0];
			mcot_s4 <= cot_s3[PW-1] ? ncot[MW-1:0] : cot_s3[MW-1:0];
			mcou_s4 <= cou_s3[PW-1] ? ncou[MW-1:0] : cou_s3[MW-1:0];
			a_s4    <= a_s3;
			d_s4    <= d_s3;
			p0x_s4  <= p0x_s3;
			p0z_s4  <= p0z_s3;
		end
	end

	// stage 5: inclusive range check of t and u, classification
	assign t_ok = (zcot_s4 || (ncot_s4 == ndet_s4)) && (mcot_s4 <= mdet_s4);
	assign u_ok = (zcou_s4 || (ncou_s4 == ndet_s4)) && (mcou_s4 <= mdet_s4);

	always_comb begin
		if (zdet_s4) begin
			status_c = (zcot_s4 && zcou_s4) ? si2d_pkg::ST_COLINEAR : si2d_pkg::ST_NONE;
		end else if (t_ok && u_ok) begin
			status_c = si2d_pkg::ST_HIT;
		end else begin
			status_c = si2d_pkg::ST_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mdet_s5 <= mdet_s4;
			mcot_s5 <= mcot_s4;
			mcou_s5 <= mcou_s4;
			side_s5 <= {p0x_s4, p0z_s4, a_s4, d_s4};
		end
	end

	assign ctl   = ctl_s5;
	assign den   = mdet_s5;
	assign rem_t = mcot_s5;
	assign rem_u = mcou_s5;
	assign side  = side_s5;

endmodule
`default_nettype wire

[rtl/si2d_div_step.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// si2d_div_step
// One restoring-division stage: yields one quotient bit of t and of u
// against the shared determinant magnitude.
// ---------------------------------------------------------------------------
module si2d_div_step #(
	parameter int CW    = si2d_pkg::COORD_WIDTH_DEF,
	parameter int FB    = si2d_pkg::FRAC_BITS_DEF,
	parameter bit FIRST = 1'b0,
	localparam int D  = CW + 1,
	localparam int MW = 2 * D - 1,
	localparam int SW = 2 * CW + 2 * D
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire si2d_pkg::ctl_t ctl_i,
	input  wire logic [MW-1:0]  den_i,
	input  wire logic [MW-1:0]  rem_t_i,
	input  wire logic [MW-1:0]  rem_u_i,
	input  wire logic [FB:0]    qt_i,
	input  wire logic [FB:0]    qu_i,
	input  wire logic [SW-1:0]  side_i,
	output si2d_pkg::ctl_t      ctl_o,
	output logic [MW-1:0]       den_o,
	output logic [MW-1:0]       rem_t_o,
	output logic [MW-1:0]       rem_u_o,
	output logic [FB:0]         qt_o,
	output logic [FB:0]         qu_o,
	output logic [SW-1:0]       side_o
);

	si2d_pkg::ctl_t ctl_q;
	logic [MW:0]    rt, ru, dt, du;
	logic           ge_t, ge_u;

	// partial remainders stay below den, so one shift fits in MW+1 bits
	assign rt   = FIRST ? {1'b0, rem_t_i} : {rem_t_i, 1'b0};
	assign ru   = FIRST ? {1'b0, rem_u_i} : {rem_u_i, 1'b0};
	assign ge_t = (rt >= {1'b0, den_i});
	assign ge_u = (ru >= {1'b0, den_i});
	assign dt   = ge_t ? (rt - {1'b0, den_i}) : rt;
	assign du   = ge_u ? (ru - {1'b0, den_i}) : ru;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o   <= den_i;
			rem_t_o <= dt[MW-1:0];
			rem_u_o <= du[MW-1:0];
			qt_o    <= {qt_i[FB-1:0], ge_t};
			qu_o    <= {qu_i[FB-1:0], ge_u};
			side_o  <= side_i;
		end
	end

	assign ctl_o = ctl_q;

endmodule
`default_nettype wire

[rtl/si2d_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// si2d_back
// Interpolation of the crossing point from t and the output register.
// ---------------------------------------------------------------------------
module si2d_back #(
	parameter int CW = si2d_pkg::COORD_WIDTH_DEF,
	parameter int FB = si2d_pkg::FRAC_BITS_DEF,
	localparam int D  = CW + 1,
	localparam int LW = D + FB + 2,
	localparam int SW = 2 * CW + 2 * D
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire si2d_pkg::ctl_t ctl_i,
	input  wire logic [FB:0]    qt_i,
	input  wire logic [FB:0]    qu_i,
	input  wire logic [SW-1:0]  side_i,
	output logic                valid,
	output logic [1:0]          status,
	output logic [CW-1:0]       cross_x,
	output logic [CW-1:0]       cross_z,
	output logic [FB:0]         t_frac,
	output logic [FB:0]         u_frac
);

	si2d_pkg::ctl_t       ctl_s1, ctl_s2;
	logic [CW-1:0]        p0x, p0z, p0x_s1, p0z_s1;
	logic signed [D-1:0]  a, d;
	logic signed [LW-1:0] px_s1, pz_s1, sx, sz;
	logic [FB:0]          qt_s1, qu_s1;
	logic                 hit;

	assign {p0x, p0z, a, d} = side_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
		end
	end

	// stage 1: delta times t
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= a * $signed({1'b0, qt_i});
			pz_s1  <= d * $signed({1'b0, qt_i});
			p0x_s1 <= p0x;
			p0z_s1 <= p0z;
			qt_s1  <= qt_i;
			qu_s1  <= qu_i;
		end
	end

	// stage 2: floor shift, add start point, clear unused fields
	assign sx  = px_s1 >>> FB;
	assign sz  = pz_s1 >>> FB;
	assign hit = (ctl_s1.status == si2d_pkg::ST_HIT);

	always_ff @(posedge clk) begin
		if (en) begin
			cross_x <= hit ? (p0x_s1 + sx[CW-1:0]) : '0;
			cross_z <= hit ? (p0z_s1 + sz[CW-1:0]) : '0;
			t_frac  <= hit ? qt_s1 : '0;
			u_frac  <= hit ? qu_s1 : '0;
		end
	end

	assign valid  = ctl_s2.valid;
	assign status = ctl_s2.status;

endmodule
`default_nettype wire

[rtl/segment_intersect_2d.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// segment_intersect_2d
// Intersection of two segments in the x-z plane, exact integer determinant,
// inclusive range check, truncated Q1.FRAC_BITS parameters.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------
//   in_ch    | in  | p/q start and end x/z, COORD_WIDTH bits signed each
//   out_ch   | out | status, cross_x, cross_z, t_frac, u_frac
//
// One item per cycle sustained while the output register is empty or taken.
// The divider yields one quotient bit per stage for t and u.
// The whole pipeline advances while the output register is empty or taken,
// and holds all stages in place otherwise.
// Reset clears only the control (valid and status) registers; the data registers are not reset.
// ---------------------------------------------------------------------------
module segment_intersect_2d #(
	parameter int COORD_WIDTH = si2d_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = si2d_pkg::FRAC_BITS_DEF,
	localparam int D  = COORD_WIDTH + 1,
	localparam int MW = 2 * D - 1,
	localparam int SW = 2 * COORD_WIDTH + 2 * D
) (
	input wire logic  clk,
	input wire logic  arst_n,
	si2d_in_if.sink   in_ch,
	si2d_out_if.source out_ch
);

	logic           en;
	si2d_pkg::ctl_t ctl_c  [0:FRAC_BITS+1];
	logic [MW-1:0]  den_c  [0:FRAC_BITS+1];
	logic [MW-1:0]  remt_c [0:FRAC_BITS+1];
	logic [MW-1:0]  remu_c [0:FRAC_BITS+1];
	logic [FRAC_BITS:0] qt_c [0:FRAC_BITS+1];
	logic [FRAC_BITS:0] qu_c [0:FRAC_BITS+1];
	logic [SW-1:0]  side_c [0:FRAC_BITS+1];

	// global advance
	assign en          = ~out_ch.valid | out_ch.ready;
	assign in_ch.ready = en;

	si2d_front #(.CW(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_ch.valid),
		.p0x      (in_ch.p_start_x),
		.p0z      (in_ch.p_start_z),
		.p1x      (in_ch.p_end_x),
		.p1z      (in_ch.p_end_z),
		.q0x      (in_ch.q_start_x),
		.q0z      (in_ch.q_start_z),
		.q1x      (in_ch.q_end_x),
		.q1z      (in_ch.q_end_z),
		.ctl      (ctl_c[0]),
		.den      (den_c[0]),
		.rem_t    (remt_c[0]),
		.rem_u    (remu_c[0]),
		.side     (side_c[0])
	);

	assign qt_c[0] = '0;
	assign qu_c[0] = '0;

	// divider chain, most significant quotient bit first
	for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
		si2d_div_step #(
			.CW    (COORD_WIDTH),
			.FB    (FRAC_BITS),
			.FIRST (k == 0)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_i   (ctl_c[k]),
			.den_i   (den_c[k]),
			.rem_t_i (remt_c[k]),
			.rem_u_i (remu_c[k]),
			.qt_i    (qt_c[k]),
			.qu_i    (qu_c[k]),
			.side_i  (side_c[k]),
			.ctl_o   (ctl_c[k+1]),
			.den_o   (den_c[k+1]),
			.rem_t_o (remt_c[k+1]),
			.rem_u_o (remu_c[k+1]),
			.qt_o    (qt_c[k+1]),
			.qu_o    (qu_c[k+1]),
			.side_o  (side_c[k+1])
		);
	end

	si2d_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_i   (ctl_c[FRAC_BITS+1]),
		.qt_i    (qt_c[FRAC_BITS+1]),
		.qu_i    (qu_c[FRAC_BITS+1]),
		.side_i  (side_c[FRAC_BITS+1]),
		.valid   (out_ch.valid),
		.status  (out_ch.status),
		.cross_x (out_ch.cross_x),
		.cross_z (out_ch.cross_z),
		.t_frac  (out_ch.t_frac),
		.u_frac  (out_ch.u_frac)
	);

`ifndef NO_ASSERTIONS
	// a stalled result holds the whole pipeline
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken while result stalled");

	// fields without meaning are cleared
	a_miss_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != si2d_pkg::ST_HIT |->
		out_ch.cross_x == '0 && out_ch.cross_z == '0 &&
		out_ch.t_frac == '0 && out_ch.u_frac == '0)
		else $error("non-hit result with nonzero fields");

	// parameters never exceed one
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.t_frac <= (FRAC_BITS+1)'(1 << FRAC_BITS) &&
		out_ch.u_frac <= (FRAC_BITS+1)'(1 << FRAC_BITS))
		else $error("parameter above one");

	// a stalled stage keeps its result for the next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
